### src/raf_pkg.sv
// Package for the rectangle aspect fit block: word types, rotation codes,
// pipeline sizing constants and the divider step function.
// No dependencies.
package raf_pkg;

  // Rotation mode and applied rotation codes.
  localparam logic [2:0] RotNone = 3'd0;
  localparam logic [2:0] Rot90   = 3'd1;
  localparam logic [2:0] Rot180  = 3'd2;
  localparam logic [2:0] Rot270  = 3'd3;
  localparam logic [2:0] RotAuto = 3'd4;

  // Pan range; the pan scaling is a shift by PanShift.
  localparam logic [10:0] PanMax   = 11'd1024;
  localparam int          PanShift = 10;

  // Divider: 32 quotient bits, DivBits of them per stage.
  localparam int DivBits   = 4;
  localparam int DivStages = 32 / DivBits;
  localparam int NumDiv    = 4;

  typedef struct packed {
    logic [15:0] src_width;
    logic [15:0] src_height;
    logic [15:0] box_x;
    logic [15:0] box_y;
    logic [15:0] box_width;
    logic [15:0] box_height;
    logic        crop_mode;
    logic [2:0]  rotation_mode;
    logic [10:0] h_pan;
    logic [10:0] v_pan;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  rotation_code;
    logic [31:0] fit_width;
    logic [31:0] fit_height;
    logic [16:0] pos_x;
    logic [16:0] pos_y;
    logic [31:0] offset_x;
    logic [31:0] offset_y;
    logic [31:0] scale_q16;
    logic        degenerate;
  } out_word_t;

  // Partial state of one restoring division.
  typedef struct packed {
    logic [15:0] rem;
    logic [31:0] nq;
  } div_state_t;

  // DivBits steps of restoring division: numerator bits leave the top of nq,
  // quotient bits enter at the bottom.
  function automatic div_state_t div_steps(div_state_t st, logic [15:0] den);
    logic [16:0] r;
    logic [31:0] q;
    r = {1'b0, st.rem};
    q = st.nq;
    for (int i = 0; i < DivBits; i++) begin
      r = {r[15:0], q[31]};
      q = {q[30:0], 1'b0};
      if (r >= {1'b0, den}) begin
        r    = r - {1'b0, den};
        q[0] = 1'b1;
      end
    end
    div_steps.rem = r[15:0];
    div_steps.nq  = q;
  endfunction

endpackage

### src/raf_if.sv
// Valid/ready channel interfaces for the rectangle aspect fit block.
// Depends on raf_pkg for the word types.
interface raf_in_if;
  logic              valid;
  logic              ready;
  raf_pkg::in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface raf_out_if;
  logic               valid;
  logic               ready;
  raf_pkg::out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### src/rectangle_aspect_fit.sv
// Top level of the rectangle aspect fit block: rotation, four pipelined
// dividers, fit/fill selection and placement. Depends on raf_pkg and raf_if.
//
// Usage: a source size, a target box, rotation mode, crop flag and pan
// positions arrive as one word on in_i; one placement word leaves on out_o.
// Both channels transfer a word when valid and ready are high at a clock edge.
// The datapath is an input stage, eight divider stages of four quotient bits
// each, a selection stage and the output register.
// A new word can be accepted every cycle while out_o is not stalled.
// Four dividers run side by side for the width-led and height-led scale and
// size, so the fit/fill choice costs no extra divider pass.
// When the receiver holds ready low with a word waiting, the whole pipeline
// holds and in_i.ready drops; nothing is lost or repeated.
// Reset clears all valid bits; the block is ready as soon as
// reset is released. The block keeps no state between words.
module rectangle_aspect_fit (
  input  logic            clk_i,
  input  logic            rst_ni,
  raf_in_if.sink          in_i,
  raf_out_if.source       out_o
);

  typedef struct packed {
    logic        degen;
    logic        crop;
    logic [1:0]  code;
    logic [15:0] bx;
    logic [15:0] by;
    logic [15:0] bw;
    logic [15:0] bh;
    logic [10:0] hp;
    logic [10:0] vp;
    logic [15:0] rw;
    logic [15:0] rh;
  } side_t;

  localparam int NStg = raf_pkg::DivStages + 1;

  logic                  adv;
  logic [NStg-1:0]       vld_q;
  side_t                 side_q [NStg];
  raf_pkg::div_state_t   div_q  [NStg][raf_pkg::NumDiv];

  // Global advance: the pipeline moves unless a finished word is stalled.
  assign adv      = !out_o.valid || out_o.ready;
  assign in_i.ready = adv;

  // Input stage: rotation, saturated pan and division operands.
  side_t               side_d;
  raf_pkg::div_state_t div_d [raf_pkg::NumDiv];
  logic                swap;
  raf_pkg::in_word_t   iw;

  always_comb begin
    iw = in_i.data;
    side_d = '0;
    swap   = 1'b0;
    side_d.degen = (iw.src_width == '0) || (iw.src_height == '0);
    side_d.crop  = iw.crop_mode;
    case (iw.rotation_mode)
      raf_pkg::RotAuto: begin
        swap = (iw.src_width > iw.src_height) != (iw.box_width > iw.box_height);
        side_d.code = swap ? raf_pkg::Rot90[1:0] : raf_pkg::RotNone[1:0];
      end
      raf_pkg::RotNone, raf_pkg::Rot180: begin
        side_d.code = iw.rotation_mode[1:0];
      end
      raf_pkg::Rot90, raf_pkg::Rot270: begin
        swap = 1'b1;
        side_d.code = iw.rotation_mode[1:0];
      end
      default: side_d.code = raf_pkg::RotNone[1:0];
    endcase
    side_d.bx = iw.box_x;
    side_d.by = iw.box_y;
    side_d.bw = iw.box_width;
    side_d.bh = iw.box_height;
    side_d.hp = (iw.h_pan > raf_pkg::PanMax) ? raf_pkg::PanMax : iw.h_pan;
    side_d.vp = (iw.v_pan > raf_pkg::PanMax) ? raf_pkg::PanMax : iw.v_pan;
    side_d.rw = swap ? iw.src_height : iw.src_width;
    side_d.rh = swap ? iw.src_width : iw.src_height;
    // Dividers: height from width, width scale, width from height, height scale.
    div_d[0].rem = '0;
    div_d[0].nq  = 32'(iw.box_width) * 32'(side_d.rh);
    div_d[1].rem = '0;
    div_d[1].nq  = {iw.box_width, 16'h0000};
    div_d[2].rem = '0;
    div_d[2].nq  = 32'(iw.box_height) * 32'(side_d.rw);
    div_d[3].rem = '0;
    div_d[3].nq  = {iw.box_height, 16'h0000};
  end

  // Valid bits of the input and divider stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NStg-2:0], in_i.valid};
    end
  end

  // Payload of the input and divider stages.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_q[0] <= side_d;
      for (int d = 0; d < raf_pkg::NumDiv; d++) begin
        div_q[0][d] <= div_d[d];
      end
      for (int s = 1; s < NStg; s++) begin
        side_q[s] <= side_q[s-1];
        div_q[s][0] <= raf_pkg::div_steps(div_q[s-1][0], side_q[s-1].rw);
        div_q[s][1] <= raf_pkg::div_steps(div_q[s-1][1], side_q[s-1].rw);
        div_q[s][2] <= raf_pkg::div_steps(div_q[s-1][2], side_q[s-1].rh);
        div_q[s][3] <= raf_pkg::div_steps(div_q[s-1][3], side_q[s-1].rh);
      end
    end
  end

  // Selection stage: width-led result unless it misses the box.
  side_t       sel_side_q;
  logic        sel_vld_q;
  logic [31:0] nw_q, nh_q, scale_q;
  logic [31:0] nw_d, nh_d, scale_d;
  logic        use_h;
  side_t       ls;

  always_comb begin
    ls    = side_q[NStg-1];
    use_h = ls.crop ? (div_q[NStg-1][0].nq < 32'(ls.bh))
                    : (div_q[NStg-1][0].nq > 32'(ls.bh));
    nw_d    = use_h ? div_q[NStg-1][2].nq : 32'(ls.bw);
    nh_d    = use_h ? 32'(ls.bh) : div_q[NStg-1][0].nq;
    scale_d = use_h ? div_q[NStg-1][3].nq : div_q[NStg-1][1].nq;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_vld_q <= 1'b0;
    end else if (adv) begin
      sel_vld_q <= vld_q[NStg-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sel_side_q <= ls;
      nw_q       <= nw_d;
      nh_q       <= nh_d;
      scale_q    <= scale_d;
    end
  end

  // Output stage: placement and pan offsets.
  raf_pkg::out_word_t out_d, out_q;
  logic               out_vld_q;
  logic [42:0]        pan_x, pan_y;
  logic [31:0]        gap_x, gap_y;

  always_comb begin
    pan_x = 43'(nw_q - 32'(sel_side_q.bw)) * 43'(sel_side_q.hp);
    pan_y = 43'(nh_q - 32'(sel_side_q.bh)) * 43'(sel_side_q.vp);
    gap_x = 32'(sel_side_q.bw) - nw_q;
    gap_y = 32'(sel_side_q.bh) - nh_q;
    out_d = '0;
    if (sel_side_q.degen) begin
      out_d.degenerate = 1'b1;
    end else begin
      out_d.rotation_code = sel_side_q.code;
      out_d.fit_width     = nw_q;
      out_d.fit_height    = nh_q;
      out_d.scale_q16     = scale_q;
      if (sel_side_q.crop) begin
        out_d.pos_x    = 17'(sel_side_q.bx);
        out_d.pos_y    = 17'(sel_side_q.by);
        out_d.offset_x = pan_x[raf_pkg::PanShift +: 32];
        out_d.offset_y = pan_y[raf_pkg::PanShift +: 32];
      end else begin
        out_d.pos_x = 17'(sel_side_q.bx) + gap_x[17:1];
        out_d.pos_y = 17'(sel_side_q.by) + gap_y[17:1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= sel_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign out_o.valid = out_vld_q;
  assign out_o.data  = out_q;

  // A degenerate word carries nothing else.
  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.data.degenerate |->
      out_o.data.fit_width == '0 && out_o.data.scale_q16 == '0 &&
      out_o.data.rotation_code == '0)
    else $error("degenerate word with nonzero fields");

  // Fill mode covers the box.
  a_fill_covers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sel_vld_q && !sel_side_q.degen && sel_side_q.crop |->
      nw_q >= 32'(sel_side_q.bw) && nh_q >= 32'(sel_side_q.bh))
    else $error("fill result smaller than box");

  // Fit mode stays inside the box.
  a_fit_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sel_vld_q && !sel_side_q.degen && !sel_side_q.crop |->
      nw_q <= 32'(sel_side_q.bw) && nh_q <= 32'(sel_side_q.bh))
    else $error("fit result larger than box");

endmodule
